// ===== rtl/core/mfv_pkg.sv =====
// shared types and constants for the block message frame validator
package mfv_pkg;

  localparam int LEN_BITS_DEFAULT = 32;

  localparam int REM_W = 24;
  localparam int IDX_W = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [REM_W-1:0] WORD_BYTES     = REM_W'(4);
  localparam logic [REM_W-1:0] PROPOSER_BYTES = REM_W'(32);
  localparam logic [REM_W-1:0] STAMP_BYTES    = REM_W'(8);
  localparam int PREFIX_BYTES = 6;

  localparam logic [7:0]  RST_EXP_VERSION      = 8'd1;
  localparam logic [7:0]  RST_EXP_BODY_VERSION = 8'd1;
  localparam logic [15:0] RST_HEADER_SIZE      = 16'd256;
  localparam logic [15:0] RST_CERT_MAX_LEN     = 16'd4096;
  localparam logic [15:0] RST_ENV_MAX_COUNT    = 16'd1024;
  localparam logic [23:0] RST_ENV_MAX_LEN      = 24'd65536;

  typedef enum logic [IDX_W-1:0] {
    REG_VERSION      = 3'd0,
    REG_BODY_VERSION = 3'd1,
    REG_HEADER_SIZE  = 3'd2,
    REG_CERT_MAX_LEN = 3'd3,
    REG_ENV_MAX_CNT  = 3'd4,
    REG_ENV_MAX_LEN  = 3'd5
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_TRUNCATED = 4'd1,
    ST_VERSION   = 4'd2,
    ST_BODY_VER  = 4'd3,
    ST_HDR_LEN   = 4'd4,
    ST_CERT_LEN  = 4'd5,
    ST_ENV_COUNT = 4'd6,
    ST_ENV_LEN   = 4'd7,
    ST_UNSUP     = 4'd8,
    ST_TRAILING  = 4'd9
  } status_t;

  typedef enum logic [3:0] {
    PH_VER   = 4'd0,
    PH_BVER  = 4'd1,
    PH_HLEN  = 4'd2,
    PH_HDR   = 4'd3,
    PH_CLEN  = 4'd4,
    PH_CERT  = 4'd5,
    PH_ECNT  = 4'd6,
    PH_ELEN  = 4'd7,
    PH_EBODY = 4'd8,
    PH_CLAIM = 4'd9,
    PH_POOL  = 4'd10,
    PH_PROP  = 4'd11,
    PH_STAMP = 4'd12,
    PH_DONE  = 4'd13
  } phase_t;

  typedef struct packed {
    logic [7:0]  exp_version;
    logic [7:0]  exp_body_version;
    logic [15:0] header_size;
    logic [15:0] cert_max_len;
    logic [15:0] env_max_count;
    logic [23:0] env_max_len;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] cert_len;
    logic [15:0] envelope_total;
    logic [63:0] stamp;
    logic [31:0] bytes_used;
  } result_t;

endpackage

// ===== rtl/core/mfv_cfg_regs.sv =====
// configuration register file
module mfv_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mfv_pkg::IDX_W-1:0]     cfg_index,
  input  logic [mfv_pkg::CFG_DATA_W-1:0] cfg_data,
  output mfv_pkg::cfg_t                 cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.exp_version      <= mfv_pkg::RST_EXP_VERSION;
      cfg.exp_body_version <= mfv_pkg::RST_EXP_BODY_VERSION;
      cfg.header_size      <= mfv_pkg::RST_HEADER_SIZE;
      cfg.cert_max_len     <= mfv_pkg::RST_CERT_MAX_LEN;
      cfg.env_max_count    <= mfv_pkg::RST_ENV_MAX_COUNT;
      cfg.env_max_len      <= mfv_pkg::RST_ENV_MAX_LEN;
    end else if (cfg_valid && cfg_ready) begin
      unique case (mfv_pkg::cfg_reg_t'(cfg_index))
        mfv_pkg::REG_VERSION:      cfg.exp_version      <= cfg_data[7:0];
        mfv_pkg::REG_BODY_VERSION: cfg.exp_body_version <= cfg_data[7:0];
        mfv_pkg::REG_HEADER_SIZE:  cfg.header_size      <= cfg_data[15:0];
        mfv_pkg::REG_CERT_MAX_LEN: cfg.cert_max_len     <= cfg_data[15:0];
        mfv_pkg::REG_ENV_MAX_CNT:  cfg.env_max_count    <= cfg_data[15:0];
        mfv_pkg::REG_ENV_MAX_LEN:  cfg.env_max_len      <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/mfv_in_stage.sv =====
// input register for incoming message bytes
module mfv_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_ready,
  input  logic [7:0]     data_byte,
  input  logic           final_byte,
  input  logic           advance,
  output logic           held_valid,
  output mfv_pkg::item_t held_item
);

  assign item_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (item_ready) begin
      held_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      held_item.data_byte  <= data_byte;
      held_item.final_byte <= final_byte;
    end
  end

endmodule

// ===== rtl/core/mfv_parser.sv =====
// layout walker: per-byte phase tracking, field assembly and checks
module mfv_parser #(
  parameter int LEN_BITS = mfv_pkg::LEN_BITS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  mfv_pkg::item_t   item,
  input  mfv_pkg::cfg_t    cfg,
  output mfv_pkg::result_t result
);

  localparam int RW = mfv_pkg::REM_W;

  mfv_pkg::phase_t  phase, phase_next;
  logic [RW-1:0]    field_remaining, field_remaining_next;
  logic [63:0]      assembly_shift, assembly_shift_next;
  logic [15:0]      envelopes_left, envelopes_left_next;
  mfv_pkg::status_t first_error, first_error_next;
  logic [15:0]      held_cert_len, held_cert_len_next;
  logic [15:0]      held_env_count, held_env_count_next;
  logic [63:0]      held_stamp, held_stamp_next;
  logic [LEN_BITS-1:0] byte_total, byte_total_next;
  logic             claim_nonzero, claim_nonzero_next;

  logic [63:0]   shifted;
  logic [31:0]   word;
  logic [RW-1:0] rem_dec;
  logic          field_done;
  logic [15:0]   left_dec;
  logic [7:0]    b;

  assign b          = item.data_byte;
  assign shifted    = {assembly_shift[55:0], b};
  assign word       = shifted[31:0];
  assign rem_dec    = (field_remaining != '0) ? field_remaining - 1'b1 : field_remaining;
  assign field_done = (rem_dec == '0);
  assign left_dec   = (envelopes_left != '0) ? envelopes_left - 1'b1 : envelopes_left;

  // next state of the walk
  always_comb begin
    phase_next           = phase;
    field_remaining_next = field_remaining;
    assembly_shift_next  = assembly_shift;
    envelopes_left_next  = envelopes_left;
    first_error_next     = first_error;
    held_cert_len_next   = held_cert_len;
    held_env_count_next  = held_env_count;
    held_stamp_next      = held_stamp;
    claim_nonzero_next   = claim_nonzero;
    byte_total_next      = (byte_total != '1) ? byte_total + 1'b1 : byte_total;

    if (first_error == mfv_pkg::ST_OK) begin
      unique case (phase)
        mfv_pkg::PH_VER: begin
          if (b != cfg.exp_version) first_error_next = mfv_pkg::ST_VERSION;
          else phase_next = mfv_pkg::PH_BVER;
        end
        mfv_pkg::PH_BVER: begin
          if (b != cfg.exp_body_version) begin
            first_error_next = mfv_pkg::ST_BODY_VER;
          end else begin
            phase_next           = mfv_pkg::PH_HLEN;
            field_remaining_next = mfv_pkg::WORD_BYTES;
            assembly_shift_next  = '0;
          end
        end
        mfv_pkg::PH_HLEN: begin
          assembly_shift_next  = shifted;
          field_remaining_next = rem_dec;
          if (field_done) begin
            if (word != 32'(cfg.header_size)) begin
              first_error_next = mfv_pkg::ST_HDR_LEN;
            end else if (word == '0) begin
              phase_next           = mfv_pkg::PH_CLEN;
              field_remaining_next = mfv_pkg::WORD_BYTES;
              assembly_shift_next  = '0;
            end else begin
              phase_next           = mfv_pkg::PH_HDR;
              field_remaining_next = word[RW-1:0];
              assembly_shift_next  = '0;
            end
          end
        end
        mfv_pkg::PH_HDR: begin
          field_remaining_next = rem_dec;
          if (field_done) begin
            phase_next           = mfv_pkg::PH_CLEN;
            field_remaining_next = mfv_pkg::WORD_BYTES;
            assembly_shift_next  = '0;
          end
        end
        mfv_pkg::PH_CLEN: begin
          assembly_shift_next  = shifted;
          field_remaining_next = rem_dec;
          if (field_done) begin
            if (word == '0 || word > 32'(cfg.cert_max_len)) begin
              first_error_next = mfv_pkg::ST_CERT_LEN;
            end else begin
              held_cert_len_next   = word[15:0];
              phase_next           = mfv_pkg::PH_CERT;
              field_remaining_next = word[RW-1:0];
              assembly_shift_next  = '0;
            end
          end
        end
        mfv_pkg::PH_CERT: begin
          field_remaining_next = rem_dec;
          if (field_done) begin
            phase_next           = mfv_pkg::PH_ECNT;
            field_remaining_next = mfv_pkg::WORD_BYTES;
            assembly_shift_next  = '0;
          end
        end
        mfv_pkg::PH_ECNT: begin
          assembly_shift_next  = shifted;
          field_remaining_next = rem_dec;
          if (field_done) begin
            if (word > 32'(cfg.env_max_count)) begin
              first_error_next = mfv_pkg::ST_ENV_COUNT;
            end else begin
              held_env_count_next  = word[15:0];
              envelopes_left_next  = word[15:0];
              phase_next           = (word == '0) ? mfv_pkg::PH_CLAIM : mfv_pkg::PH_ELEN;
              field_remaining_next = mfv_pkg::WORD_BYTES;
              assembly_shift_next  = '0;
            end
          end
        end
        mfv_pkg::PH_ELEN: begin
          assembly_shift_next  = shifted;
          field_remaining_next = rem_dec;
          if (field_done) begin
            if (word == '0 || word > 32'(cfg.env_max_len)) begin
              first_error_next = mfv_pkg::ST_ENV_LEN;
            end else begin
              phase_next           = mfv_pkg::PH_EBODY;
              field_remaining_next = word[RW-1:0];
              assembly_shift_next  = '0;
            end
          end
        end
        mfv_pkg::PH_EBODY: begin
          field_remaining_next = rem_dec;
          if (field_done) begin
            envelopes_left_next  = left_dec;
            phase_next           = (left_dec == '0) ? mfv_pkg::PH_CLAIM : mfv_pkg::PH_ELEN;
            field_remaining_next = mfv_pkg::WORD_BYTES;
            assembly_shift_next  = '0;
          end
        end
        mfv_pkg::PH_CLAIM: begin
          assembly_shift_next  = shifted;
          field_remaining_next = rem_dec;
          if (field_done) begin
            claim_nonzero_next   = (word != '0);
            phase_next           = mfv_pkg::PH_POOL;
            field_remaining_next = mfv_pkg::WORD_BYTES;
            assembly_shift_next  = '0;
          end
        end
        mfv_pkg::PH_POOL: begin
          assembly_shift_next  = shifted;
          field_remaining_next = rem_dec;
          if (field_done) begin
            if (claim_nonzero || word != '0) begin
              first_error_next = mfv_pkg::ST_UNSUP;
            end else begin
              phase_next           = mfv_pkg::PH_PROP;
              field_remaining_next = mfv_pkg::PROPOSER_BYTES;
              assembly_shift_next  = '0;
            end
          end
        end
        mfv_pkg::PH_PROP: begin
          field_remaining_next = rem_dec;
          if (field_done) begin
            phase_next           = mfv_pkg::PH_STAMP;
            field_remaining_next = mfv_pkg::STAMP_BYTES;
            assembly_shift_next  = '0;
          end
        end
        mfv_pkg::PH_STAMP: begin
          assembly_shift_next  = shifted;
          field_remaining_next = rem_dec;
          if (field_done) begin
            held_stamp_next = shifted;
            phase_next      = mfv_pkg::PH_DONE;
          end
        end
        default: first_error_next = mfv_pkg::ST_TRAILING;
      endcase
    end
  end

  // result seen on the final byte
  always_comb begin
    if (byte_total_next < LEN_BITS'(mfv_pkg::PREFIX_BYTES)) begin
      result.status = mfv_pkg::ST_TRUNCATED;
    end else if (first_error_next != mfv_pkg::ST_OK) begin
      result.status = first_error_next;
    end else if (phase_next != mfv_pkg::PH_DONE) begin
      result.status = mfv_pkg::ST_TRUNCATED;
    end else begin
      result.status = mfv_pkg::ST_OK;
    end
    if (result.status == mfv_pkg::ST_OK) begin
      result.cert_len       = held_cert_len_next;
      result.envelope_total = held_env_count_next;
      result.stamp          = held_stamp_next;
      result.bytes_used     = 32'(byte_total_next);
    end else begin
      result.cert_len       = '0;
      result.envelope_total = '0;
      result.stamp          = '0;
      result.bytes_used     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && item.final_byte)) begin
      phase           <= mfv_pkg::PH_VER;
      field_remaining <= '0;
      assembly_shift  <= '0;
      envelopes_left  <= '0;
      first_error     <= mfv_pkg::ST_OK;
      held_cert_len   <= '0;
      held_env_count  <= '0;
      held_stamp      <= '0;
      byte_total      <= '0;
      claim_nonzero   <= 1'b0;
    end else if (step) begin
      phase           <= phase_next;
      field_remaining <= field_remaining_next;
      assembly_shift  <= assembly_shift_next;
      envelopes_left  <= envelopes_left_next;
      first_error     <= first_error_next;
      held_cert_len   <= held_cert_len_next;
      held_env_count  <= held_env_count_next;
      held_stamp      <= held_stamp_next;
      byte_total      <= byte_total_next;
      claim_nonzero   <= claim_nonzero_next;
    end
  end

endmodule

// ===== rtl/core/mfv_out_stage.sv =====
// result register toward the downstream channel
module mfv_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  mfv_pkg::result_t result_in,
  output logic             free,
  output logic             result_valid,
  input  logic             result_ready,
  output mfv_pkg::result_t result_out
);

  assign free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_out <= result_in;
    end
  end

endmodule

// ===== rtl/core/block_message_frame_validator_unit.sv =====
// top level of the block message frame validator
// Takes one message byte per beat, with final_byte set on the last one, and gives one
// result beat per message: a status and, when the status is ok, the certificate length,
// envelope count, timestamp and message length in bytes. Each byte passes an input
// register and then the field logic, so a byte can be taken in every cycle unless a final
// byte waits; a result is registered in the output register in the cycle after the final
// byte passes the field logic, so bytes keep flowing while it waits. A final byte waits
// in the input register only while the previous result is still held and not taken. The
// byte count is LEN_BITS wide and saturates. Configuration writes are taken at once and
// should be made between messages.
module block_message_frame_validator_unit #(
  parameter int LEN_BITS = mfv_pkg::LEN_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  logic [7:0]                     data_byte,
  input  logic                           final_byte,
  output logic                           result_valid,
  input  logic                           result_ready,
  output logic [3:0]                     status,
  output logic [15:0]                    cert_len,
  output logic [15:0]                    envelope_total,
  output logic [63:0]                    stamp,
  output logic [31:0]                    bytes_used,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mfv_pkg::IDX_W-1:0]      cfg_index,
  input  logic [mfv_pkg::CFG_DATA_W-1:0] cfg_data
);

  mfv_pkg::cfg_t    cfg;
  mfv_pkg::item_t   held_item;
  mfv_pkg::result_t result_next;
  mfv_pkg::result_t result_q;
  logic             held_valid;
  logic             out_free;
  logic             step;

  assign step = held_valid && (!held_item.final_byte || out_free);

  mfv_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mfv_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .data_byte  (data_byte),
    .final_byte (final_byte),
    .advance    (step),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  mfv_parser #(
    .LEN_BITS (LEN_BITS)
  ) u_parser (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (held_item),
    .cfg    (cfg),
    .result (result_next)
  );

  mfv_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (step && held_item.final_byte),
    .result_in    (result_next),
    .free         (out_free),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_out   (result_q)
  );

  assign status         = result_q.status;
  assign cert_len       = result_q.cert_len;
  assign envelope_total = result_q.envelope_total;
  assign stamp          = result_q.stamp;
  assign bytes_used     = result_q.bytes_used;

endmodule

// ===== verif/block_message_frame_validator_unit_test.sv =====
// self-checking testbench for the block message frame validator unit
`timescale 1ns / 100ps

module block_message_frame_validator_unit_test;
  import mfv_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_OFF = 4;

  typedef enum int {
    FL_NONE, FL_VERSION, FL_BODY_VER, FL_HDR_LEN, FL_CERT_ZERO, FL_CERT_BIG,
    FL_ENV_COUNT, FL_ENV_ZERO, FL_ENV_BIG, FL_CLAIM, FL_POOL, FL_TRAILING,
    FL_TRUNCATE, FL_SHORT, FL_NOISE
  } flaw_t;

  class frame_judge;
    cfg_t regs;
    phase_t ph;
    bit [31:0] left;
    bit [63:0] shreg;
    bit [15:0] env_left;
    status_t err;
    bit [15:0] cert_hold;
    bit [15:0] env_hold;
    bit [63:0] stamp_hold;
    bit [31:0] total;
    bit claim_seen;
    result_t awaited[$];
    int fails;

    function new();
      regs = '{RST_EXP_VERSION, RST_EXP_BODY_VERSION, RST_HEADER_SIZE,
               RST_CERT_MAX_LEN, RST_ENV_MAX_COUNT, RST_ENV_MAX_LEN};
      fails = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      ph = PH_VER;
      left = 0;
      shreg = 0;
      env_left = 0;
      err = ST_OK;
      cert_hold = 0;
      env_hold = 0;
      stamp_hold = 0;
      total = 0;
      claim_seen = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, bit [23:0] d);
      case (idx)
        REG_VERSION: regs.exp_version = d[7:0];
        REG_BODY_VERSION: regs.exp_body_version = d[7:0];
        REG_HEADER_SIZE: regs.header_size = d[15:0];
        REG_CERT_MAX_LEN: regs.cert_max_len = d[15:0];
        REG_ENV_MAX_CNT: regs.env_max_count = d[15:0];
        REG_ENV_MAX_LEN: regs.env_max_len = d[23:0];
        default: ;
      endcase
    endfunction

    function void open_field(phase_t p, bit [31:0] n);
      ph = p;
      left = n;
      shreg = 0;
    endfunction

    function bit shift_in(bit [7:0] b);
      shreg = {shreg[55:0], b};
      if (left > 0) left--;
      return left == 0;
    endfunction

    function bit skip_one();
      if (left > 0) left--;
      return left == 0;
    endfunction

    function void advance(bit [7:0] b);
      bit [31:0] v;
      case (ph)
        PH_VER: begin
          if (b != regs.exp_version) err = ST_VERSION;
          else ph = PH_BVER;
        end
        PH_BVER: begin
          if (b != regs.exp_body_version) err = ST_BODY_VER;
          else open_field(PH_HLEN, WORD_BYTES);
        end
        PH_HLEN: begin
          if (shift_in(b)) begin
            v = shreg[31:0];
            if (v != {16'd0, regs.header_size}) err = ST_HDR_LEN;
            else if (v == 0) open_field(PH_CLEN, WORD_BYTES);
            else open_field(PH_HDR, v);
          end
        end
        PH_HDR: begin
          if (skip_one()) open_field(PH_CLEN, WORD_BYTES);
        end
        PH_CLEN: begin
          if (shift_in(b)) begin
            v = shreg[31:0];
            if (v == 0 || v > {16'd0, regs.cert_max_len}) begin
              err = ST_CERT_LEN;
            end else begin
              cert_hold = v[15:0];
              open_field(PH_CERT, v);
            end
          end
        end
        PH_CERT: begin
          if (skip_one()) open_field(PH_ECNT, WORD_BYTES);
        end
        PH_ECNT: begin
          if (shift_in(b)) begin
            v = shreg[31:0];
            if (v > {16'd0, regs.env_max_count}) begin
              err = ST_ENV_COUNT;
            end else begin
              env_hold = v[15:0];
              env_left = v[15:0];
              if (v == 0) open_field(PH_CLAIM, WORD_BYTES);
              else open_field(PH_ELEN, WORD_BYTES);
            end
          end
        end
        PH_ELEN: begin
          if (shift_in(b)) begin
            v = shreg[31:0];
            if (v == 0 || v > {8'd0, regs.env_max_len}) err = ST_ENV_LEN;
            else open_field(PH_EBODY, v);
          end
        end
        PH_EBODY: begin
          if (skip_one()) begin
            if (env_left > 0) env_left--;
            if (env_left == 0) open_field(PH_CLAIM, WORD_BYTES);
            else open_field(PH_ELEN, WORD_BYTES);
          end
        end
        PH_CLAIM: begin
          if (shift_in(b)) begin
            claim_seen = (shreg[31:0] != 0);
            open_field(PH_POOL, WORD_BYTES);
          end
        end
        PH_POOL: begin
          if (shift_in(b)) begin
            if (claim_seen || shreg[31:0] != 0) err = ST_UNSUP;
            else open_field(PH_PROP, PROPOSER_BYTES);
          end
        end
        PH_PROP: begin
          if (skip_one()) open_field(PH_STAMP, STAMP_BYTES);
        end
        PH_STAMP: begin
          if (shift_in(b)) begin
            stamp_hold = shreg;
            ph = PH_DONE;
          end
        end
        default: err = ST_TRAILING;
      endcase
    endfunction

    function void take_byte(bit [7:0] b, bit last);
      result_t r;
      status_t st;
      if (err == ST_OK) advance(b);
      if (total != 32'hFFFF_FFFF) total++;
      if (last) begin
        if (total < PREFIX_BYTES) st = ST_TRUNCATED;
        else if (err != ST_OK) st = err;
        else if (ph != PH_DONE) st = ST_TRUNCATED;
        else st = ST_OK;
        r = '0;
        r.status = st;
        if (st == ST_OK) begin
          r.cert_len = cert_hold;
          r.envelope_total = env_hold;
          r.stamp = stamp_hold;
          r.bytes_used = total;
        end
        awaited.push_back(r);
        clear_frame();
      end
    endfunction

    function void check_verdict(result_t got);
      result_t want;
      if (awaited.size() == 0) begin
        $display("%0t: result beat with nothing awaited, status %0d", $time, got.status);
        fails++;
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
        fails++;
      end
      if (got.cert_len !== want.cert_len) begin
        $display("%0t: cert_len expected %0d, got %0d", $time, want.cert_len, got.cert_len);
        fails++;
      end
      if (got.envelope_total !== want.envelope_total) begin
        $display("%0t: envelope_total expected %0d, got %0d", $time,
                 want.envelope_total, got.envelope_total);
        fails++;
      end
      if (got.stamp !== want.stamp) begin
        $display("%0t: stamp expected %h, got %h", $time, want.stamp, got.stamp);
        fails++;
      end
      if (got.bytes_used !== want.bytes_used) begin
        $display("%0t: bytes_used expected %0d, got %0d", $time,
                 want.bytes_used, got.bytes_used);
        fails++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  logic [7:0] data_byte = 8'd0;
  logic final_byte = 1'b0;
  logic result_valid;
  logic result_ready = 1'b0;
  logic [3:0] status;
  logic [15:0] cert_len;
  logic [15:0] envelope_total;
  logic [63:0] stamp;
  logic [31:0] bytes_used;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  frame_judge judge;
  bit [7:0] frame_bytes[$];
  int snd_idle = 15;
  int rcv_idle = 64;
  int sent_bytes = 0;
  int frames_sent = 0;
  int quiet_cycles = 0;

  block_message_frame_validator_unit uut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .data_byte(data_byte),
    .final_byte(final_byte),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .status(status),
    .cert_len(cert_len),
    .envelope_total(envelope_total),
    .stamp(stamp),
    .bytes_used(bytes_used),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    result_ready <= ($urandom_range(99) >= rcv_idle);
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      judge.check_verdict({status, cert_len, envelope_total, stamp, bytes_used});
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic void put_word(bit [31:0] w);
    frame_bytes.push_back(w[31:24]);
    frame_bytes.push_back(w[23:16]);
    frame_bytes.push_back(w[15:8]);
    frame_bytes.push_back(w[7:0]);
  endfunction

  function automatic void put_junk(int n);
    repeat (n) frame_bytes.push_back(8'($urandom));
  endfunction

  function automatic bit [31:0] nonzero_word();
    return $urandom | (32'h1 << $urandom_range(31));
  endfunction

  // lays out one frame, stopping shortly after the chosen flaw, if any, or inside a header too long to send whole
  function automatic void build_layout(flaw_t base);
    cfg_t c;
    int n, k, bad;
    bit [31:0] len, cap;
    c = judge.regs;
    frame_bytes.delete();
    if (base == FL_NOISE) begin
      put_junk($urandom_range(1, 40));
      return;
    end
    if (base == FL_VERSION) begin
      frame_bytes.push_back(c.exp_version ^ 8'($urandom_range(1, 255)));
      put_junk($urandom_range(0, 6));
      return;
    end
    frame_bytes.push_back(c.exp_version);
    if (base == FL_BODY_VER) begin
      frame_bytes.push_back(c.exp_body_version ^ 8'($urandom_range(1, 255)));
      put_junk($urandom_range(0, 6));
      return;
    end
    frame_bytes.push_back(c.exp_body_version);
    if (base == FL_HDR_LEN) begin
      put_word({16'd0, c.header_size} ^ (32'h1 << $urandom_range(31)));
      put_junk($urandom_range(0, 6));
      return;
    end
    put_word({16'd0, c.header_size});
    // header too long to send whole: the frame ends inside it
    if (c.header_size > 64) begin
      put_junk(10);
      return;
    end
    put_junk(c.header_size);
    if (base == FL_CERT_ZERO || base == FL_CERT_BIG) begin
      put_word(base == FL_CERT_ZERO ? 32'd0 :
               {16'd0, c.cert_max_len} + $urandom_range(1, 70000));
      put_junk($urandom_range(0, 6));
      return;
    end
    cap = (c.cert_max_len == 0 || c.cert_max_len > 8) ? 8 : c.cert_max_len;
    len = $urandom_range(1, cap);
    if ($urandom_range(3) == 0 && c.cert_max_len != 0 && c.cert_max_len <= 64) begin
      len = c.cert_max_len;
    end
    put_word(len);
    put_junk(len);
    if (base == FL_ENV_COUNT) begin
      put_word({16'd0, c.env_max_count} + $urandom_range(1, 70000));
      put_junk($urandom_range(0, 6));
      return;
    end
    n = $urandom_range(0, c.env_max_count < 3 ? c.env_max_count : 3);
    bad = (n == 0) ? -1 : $urandom_range(0, n - 1);
    put_word(n);
    for (k = 0; k < n; k++) begin
      if (k == bad && (base == FL_ENV_ZERO || base == FL_ENV_BIG)) begin
        put_word(base == FL_ENV_ZERO ? 32'd0 :
                 {8'd0, c.env_max_len} + $urandom_range(1, 70000));
        put_junk($urandom_range(0, 6));
        return;
      end
      cap = (c.env_max_len == 0 || c.env_max_len > 6) ? 6 : c.env_max_len;
      len = $urandom_range(1, cap);
      put_word(len);
      put_junk(len);
    end
    put_word(base == FL_CLAIM ? nonzero_word() : 32'd0);
    put_word(base == FL_POOL ? nonzero_word() : 32'd0);
    if (base == FL_CLAIM || base == FL_POOL) begin
      put_junk($urandom_range(0, 6));
      return;
    end
    put_junk(PROPOSER_BYTES);
    put_word($urandom);
    put_word($urandom);
    if (base == FL_TRAILING) put_junk($urandom_range(1, 4));
  endfunction

  function automatic flaw_t pick_flaw();
    if ($urandom_range(1) == 0) return FL_NONE;
    return flaw_t'($urandom_range(1, FL_NOISE));
  endfunction

  // valid is left high after the last beat; the next frame or quiesce() drives it
  task automatic send_frame();
    int i;
    for (i = 0; i < frame_bytes.size(); i++) begin
      if ($urandom_range(99) < snd_idle) begin
        item_valid <= 1'b0;
        do @(posedge clk); while ($urandom_range(99) < snd_idle);
      end
      item_valid <= 1'b1;
      data_byte <= frame_bytes[i];
      final_byte <= (i == frame_bytes.size() - 1);
      do @(posedge clk); while (!item_ready);
      judge.take_byte(frame_bytes[i], i == frame_bytes.size() - 1);
      sent_bytes++;
    end
  endtask

  task automatic run_frame(flaw_t fl);
    flaw_t base;
    int cut;
    base = fl;
    if (fl == FL_TRUNCATE) base = FL_NONE;
    if (fl == FL_SHORT) begin
      case ($urandom_range(2))
        0: base = FL_NONE;
        1: base = FL_VERSION;
        default: base = FL_BODY_VER;
      endcase
    end
    build_layout(base);
    cut = frame_bytes.size();
    if (fl == FL_TRUNCATE && frame_bytes.size() > 6) cut = $urandom_range(6, frame_bytes.size() - 1);
    if (fl == FL_SHORT) cut = $urandom_range(1, 5);
    while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
    send_frame();
    frames_sent++;
  endtask

  task automatic quiesce();
    item_valid <= 1'b0;
    while (judge.awaited.size() != 0) @(posedge clk);
    repeat (HOLD_OFF) @(posedge clk);
  endtask

  task automatic write_settings(input cfg_t c);
    bit [23:0] vals[6];
    int i;
    vals[REG_VERSION] = c.exp_version;
    vals[REG_BODY_VERSION] = c.exp_body_version;
    vals[REG_HEADER_SIZE] = c.header_size;
    vals[REG_CERT_MAX_LEN] = c.cert_max_len;
    vals[REG_ENV_MAX_CNT] = c.env_max_count;
    vals[REG_ENV_MAX_LEN] = c.env_max_len;
    for (i = 0; i <= REG_ENV_MAX_LEN; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= IDX_W'(i);
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      judge.set_reg(cfg_reg_t'(i), vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    cfg_t plan[7];
    int p, k, i;
    judge = new();
    plan[0] = '{8'd255, 8'd0, 16'd0, 16'd65535, 16'd65535, 24'hFF_FFFF};
    plan[1] = '{8'd0, 8'd255, 16'd5, 16'd1, 16'd0, 24'd1};
    plan[2] = '{8'($urandom), 8'($urandom), 16'd3, 16'd0, 16'd3, 24'd0};
    plan[3] = '{8'($urandom), 8'($urandom), 16'd12, 16'd8, 16'd2, 24'd4};
    plan[4] = '{8'($urandom), 8'($urandom), 16'd65535, 16'd40, 16'd3, 24'd6};
    plan[5] = '{8'($urandom), 8'($urandom), 16'($urandom_range(0, 20)),
                16'($urandom_range(1, 64)), 16'($urandom_range(0, 5)),
                24'($urandom_range(1, 10))};
    plan[6] = '{RST_EXP_VERSION, RST_EXP_BODY_VERSION, RST_HEADER_SIZE,
                RST_CERT_MAX_LEN, RST_ENV_MAX_COUNT, RST_ENV_MAX_LEN};
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // settings after reset, before any register write
    run_frame(FL_NONE);
    run_frame(FL_SHORT);
    run_frame(FL_VERSION);
    run_frame(FL_HDR_LEN);

    for (p = 0; p < 7; p++) begin
      quiesce();
      if (p == 3) begin
        snd_idle = 64;
        rcv_idle = 15;
      end
      if (p == 5) begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      write_settings(plan[p]);
      if (p == 0) begin
        for (i = FL_NONE; i <= FL_NOISE; i++) run_frame(flaw_t'(i));
      end
      for (k = 0; k < (plan[p].header_size > 64 ? 2 : 3); k++) run_frame(pick_flaw());
    end
    while (sent_bytes < 1100 || frames_sent < 40) run_frame(pick_flaw());
    quiesce();

    if (judge.fails == 0 && judge.awaited.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== block_message_frame_validator_unit.f =====
rtl/core/mfv_pkg.sv
rtl/core/mfv_cfg_regs.sv
rtl/core/mfv_in_stage.sv
rtl/core/mfv_parser.sv
rtl/core/mfv_out_stage.sv
rtl/core/block_message_frame_validator_unit.sv
verif/block_message_frame_validator_unit_test.sv
